>>> design/sal_pkg.sv
`default_nettype none

package sal_pkg;

  // Field widths of the stream words.
  localparam int OP_W       = 3;
  localparam int VAL_W      = 32;
  localparam int POS_W      = 6;
  localparam int STAT_W     = 3;
  localparam int CNT_OUT_W  = 7;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Operation codes carried on in_tuser.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_READ       = 3'd5,
    OP_FIND       = 3'd6
  } op_t;

  // Result status carried on out_tuser.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_RANGE     = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  // What each storage cell does with its entry this cycle.
  typedef enum logic [1:0] {
    EN_HOLD       = 2'd0,
    EN_SHIFT_UP   = 2'd1,
    EN_SHIFT_DOWN = 2'd2,
    EN_WRITE_AT   = 2'd3
  } entry_op_t;

  // What each cell does with its stage of the result chain.
  typedef enum logic [1:0] {
    BUS_HOLD = 2'd0,
    BUS_LOAD = 2'd1,
    BUS_STEP = 2'd2
  } bus_op_t;

  // Command broadcast to every cell.
  typedef struct packed {
    entry_op_t entry_op;
    bus_op_t   bus_op;
    logic      find;
  } cell_cmd_t;

  // One result word.
  typedef struct packed {
    logic [CNT_OUT_W-1:0] count;
    status_t              status;
    logic [POS_W-1:0]     found_position;
    logic [VAL_W-1:0]     value_out;
  } result_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SWEEP  = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

endpackage

`default_nettype wire

>>> design/sal_cell.sv
`default_nettype none

module sal_cell #(
  parameter int WORD_BITS = 32,
  parameter int CNT_W     = 7,
  parameter int SEL_W     = 7,
  parameter int IDX_W     = 6,
  parameter int CELL_IDX  = 0
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire sal_pkg::cell_cmd_t cmd,
  input  wire [CNT_W-1:0]       count,
  input  wire [SEL_W-1:0]       sel,
  input  wire [WORD_BITS-1:0]   key,
  input  wire [WORD_BITS-1:0]   new_word,
  input  wire [WORD_BITS-1:0]   below_word,
  input  wire [WORD_BITS-1:0]   above_word,
  input  wire                   above_hit,
  input  wire [WORD_BITS-1:0]   above_bus_word,
  input  wire [IDX_W-1:0]       above_idx,
  output logic [WORD_BITS-1:0]  entry,
  output logic                  bus_hit,
  output logic [WORD_BITS-1:0]  bus_word,
  output logic [IDX_W-1:0]      bus_idx
);
  import sal_pkg::*;

  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);
  localparam logic [SEL_W-1:0] MY_SEL = SEL_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [WORD_BITS-1:0] entry_r, entry_nxt;
  logic                 hit_r, hit_nxt;
  logic [WORD_BITS-1:0] bword_r, bword_nxt;
  logic [IDX_W-1:0]     bidx_r, bidx_nxt;
  logic                 live;
  logic                 match;

  // A cell only takes part in a search while it lies inside the list.
  assign live  = MY_CNT < count;
  assign match = live && (cmd.find ? (entry_r == key) : (MY_SEL == sel));

  // Entry movement: shift toward either neighbor or load the new word.
  always_comb begin
    entry_nxt = entry_r;
    case (cmd.entry_op)
      EN_HOLD:       entry_nxt = entry_r;
      EN_SHIFT_UP:   entry_nxt = below_word;
      EN_SHIFT_DOWN: if (MY_SEL >= sel) entry_nxt = above_word;
      EN_WRITE_AT:   if (MY_SEL == sel) entry_nxt = new_word;
      default:       entry_nxt = entry_r;
    endcase
  end

  // Result chain: a matching cell takes over, otherwise the upper stage moves down.
  always_comb begin
    hit_nxt   = hit_r;
    bword_nxt = bword_r;
    bidx_nxt  = bidx_r;
    case (cmd.bus_op)
      BUS_HOLD: begin
        hit_nxt = hit_r;
      end
      BUS_LOAD: begin
        hit_nxt   = match;
        bword_nxt = entry_r;
        bidx_nxt  = MY_IDX;
      end
      BUS_STEP: begin
        if (match) begin
          hit_nxt   = 1'b1;
          bword_nxt = entry_r;
          bidx_nxt  = MY_IDX;
        end else begin
          hit_nxt   = above_hit;
          bword_nxt = above_bus_word;
          bidx_nxt  = above_idx;
        end
      end
      default: begin
        hit_nxt = hit_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    bword_r <= bword_nxt;
    bidx_r  <= bidx_nxt;
  end

  assign entry    = entry_r;
  assign bus_hit  = hit_r;
  assign bus_word = bword_r;
  assign bus_idx  = bidx_r;

endmodule

`default_nettype wire

>>> design/shifting_array_list.sv
`default_nettype none

// Ordered list of up to DEPTH words kept in a row of register cells, one entry
// per cell. Each input word carries one operation on in_tuser and gives one
// result word: push back, push front, pop front, an unused code (status OK)
// and every failing operation (full, empty, position out of range, find on
// an empty list) finish at acceptance, and their result is registered in the
// output register, or in the skid stage while the output stalls. Read, remove,
// pop back and find use the result chain, which moves one cell per cycle toward
// cell 0; they load the chain at acceptance, step it while sweeping and give
// their result in the finish state. One operation is in flight at a time, and a
// new word is taken while one finished result still waits at the output. Entries
// beyond the count hold stale data and are never read.
module shifting_array_list #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // in_tdata: value [31:0], position [37:32], zero [39:38]
  input  wire [sal_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: operation [2:0]
  input  wire [sal_pkg::OP_W-1:0]         in_tuser,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // out_tdata: value_out [31:0], found_position [37:32], count [44:38], zero [47:45]
  output logic [sal_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: status [2:0]
  output logic [sal_pkg::STAT_W-1:0]      out_tuser,
  output logic                            out_tvalid,
  input  wire                             out_tready
);
  import sal_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int SEL_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Sequencer and list state.
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     remain_r, remain_nxt;
  op_t                  op_r, op_nxt;
  logic [SEL_W-1:0]     sel_r, sel_nxt;
  logic [WORD_BITS-1:0] key_r, key_nxt;

  // Output register and skid stage.
  logic    out_v_r, out_v_nxt;
  result_t out_r, out_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t skid_r, skid_nxt;

  // Broadcast to the cells.
  cell_cmd_t            cmd;
  logic [SEL_W-1:0]     sel;
  logic [WORD_BITS-1:0] key;

  // Cell row wiring.
  logic [WORD_BITS-1:0] entry_w    [DEPTH];
  logic [DEPTH-1:0]     bus_hit_w;
  logic [WORD_BITS-1:0] bus_word_w [DEPTH];
  logic [IDX_W-1:0]     bus_idx_w  [DEPTH];

  // Input word fields.
  logic                 acc;
  op_t                  in_op;
  logic [WORD_BITS-1:0] in_word;
  logic [SEL_W-1:0]     pos_ext;
  logic [SEL_W-1:0]     cnt_ext;
  logic                 full;
  logic                 empty;

  logic    res_v;
  result_t res;

  assign acc     = in_tvalid && in_tready;
  assign in_op   = op_t'(in_tuser);
  assign in_word = WORD_BITS'(in_tdata[VAL_W-1:0]);
  assign pos_ext = SEL_W'(in_tdata[VAL_W+POS_W-1:VAL_W]);
  assign cnt_ext = SEL_W'(count_r);
  assign full    = count_r == FULL_CNT;
  assign empty   = count_r == '0;

  assign in_tready = (state_r == ST_IDLE) && !skid_v_r;

  // Row of storage cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_row
    logic [WORD_BITS-1:0] below_w;
    logic [WORD_BITS-1:0] above_w;
    logic                 above_hit_w;
    logic [WORD_BITS-1:0] above_bus_w;
    logic [IDX_W-1:0]     above_idx_w;

    if (i == 0) begin : g_bottom
      assign below_w = in_word;
    end else begin : g_below
      assign below_w = entry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign above_w     = '0;
      assign above_hit_w = 1'b0;
      assign above_bus_w = '0;
      assign above_idx_w = '0;
    end else begin : g_above
      assign above_w     = entry_w[i+1];
      assign above_hit_w = bus_hit_w[i+1];
      assign above_bus_w = bus_word_w[i+1];
      assign above_idx_w = bus_idx_w[i+1];
    end

    sal_cell #(
      .WORD_BITS (WORD_BITS),
      .CNT_W     (CNT_W),
      .SEL_W     (SEL_W),
      .IDX_W     (IDX_W),
      .CELL_IDX  (i)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .cmd            (cmd),
      .count          (count_r),
      .sel            (sel),
      .key            (key),
      .new_word       (in_word),
      .below_word     (below_w),
      .above_word     (above_w),
      .above_hit      (above_hit_w),
      .above_bus_word (above_bus_w),
      .above_idx      (above_idx_w),
      .entry          (entry_w[i]),
      .bus_hit        (bus_hit_w[i]),
      .bus_word       (bus_word_w[i]),
      .bus_idx        (bus_idx_w[i])
    );
  end

  // Operation sequencer.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    remain_nxt = remain_r;
    op_nxt     = op_r;
    sel_nxt    = sel_r;
    key_nxt    = key_r;
    cmd        = '{entry_op: EN_HOLD, bus_op: BUS_HOLD, find: 1'b0};
    sel        = sel_r;
    key        = key_r;
    res_v      = 1'b0;
    res        = '{count: '0, status: STAT_OK, found_position: '0, value_out: '0};

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          res_v = 1'b1;
          key   = in_word;
          case (in_op)
            OP_PUSH_BACK: begin
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                cmd.entry_op = EN_WRITE_AT;
                sel          = cnt_ext;
                count_nxt    = count_r + CNT_W'(1);
              end
            end
            OP_PUSH_FRONT: begin
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                cmd.entry_op = EN_SHIFT_UP;
                count_nxt    = count_r + CNT_W'(1);
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                res.status = STAT_EMPTY;
              end else begin
                res_v = 1'b0;
                sel   = SEL_W'(count_r - CNT_W'(1));
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                res.status = STAT_EMPTY;
              end else begin
                res.value_out = VAL_W'(entry_w[0]);
                cmd.entry_op  = EN_SHIFT_DOWN;
                sel           = '0;
                count_nxt     = count_r - CNT_W'(1);
              end
            end
            OP_REMOVE, OP_READ: begin
              if (pos_ext >= cnt_ext) begin
                res.status = STAT_RANGE;
              end else begin
                res_v = 1'b0;
                sel   = pos_ext;
              end
            end
            OP_FIND: begin
              if (empty) begin
                res.status = STAT_NOT_FOUND;
              end else begin
                res_v    = 1'b0;
                cmd.find = 1'b1;
              end
            end
            default: begin
              res.status = STAT_OK;
            end
          endcase

          // Operations that search the row start the result chain here.
          if (!res_v) begin
            cmd.bus_op = BUS_LOAD;
            op_nxt     = in_op;
            sel_nxt    = sel;
            key_nxt    = in_word;
            remain_nxt = count_r - CNT_W'(1);
            state_nxt  = (count_r == CNT_W'(1)) ? ST_FINISH : ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        cmd.bus_op = BUS_STEP;
        cmd.find   = op_r == OP_FIND;
        remain_nxt = remain_r - CNT_W'(1);
        if (remain_r == CNT_W'(1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        res_v     = 1'b1;
        state_nxt = ST_IDLE;
        if (op_r == OP_FIND) begin
          if (bus_hit_w[0]) begin
            res.found_position = POS_W'(bus_idx_w[0]);
          end else begin
            res.status = STAT_NOT_FOUND;
          end
        end else begin
          res.value_out = VAL_W'(bus_word_w[0]);
        end
        if (op_r == OP_POP_BACK) begin
          count_nxt = count_r - CNT_W'(1);
        end
        if (op_r == OP_REMOVE) begin
          cmd.entry_op = EN_SHIFT_DOWN;
          count_nxt    = count_r - CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.count = CNT_OUT_W'(count_nxt);
  end

  // Output register with one skid stage behind it.
  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_nxt    = skid_r;
        skid_v_nxt = res_v;
        skid_nxt   = res;
      end else begin
        out_v_nxt = res_v;
        out_nxt   = res;
      end
    end else if (res_v) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      remain_r <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      remain_r <= remain_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    sel_r  <= sel_nxt;
    key_r  <= key_nxt;
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = OUT_DATA_W'({out_r.count, out_r.found_position, out_r.value_out});

  // The list never holds more entries than there are cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count beyond depth");

  // The skid stage only fills behind a waiting output word.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid stage holds a word ahead of the output register");

  // Read, remove and pop back always target an entry inside the list.
  a_target_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && op_r != OP_FIND) |-> bus_hit_w[0])
    else $error("result chain lost the addressed entry");

  // A successful push back grows the list by one.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_op == OP_PUSH_BACK && !full) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("push back did not grow the list");

endmodule

`default_nettype wire
